FILE: sv/satq_pkg.sv
// shared types and constants for the sorted alarm timer queue
`timescale 1ns / 1ps
`default_nettype none

package satq_pkg;

    localparam int OP_W    = 2;
    localparam int OBJ_W   = 3;
    localparam int DELAY_W = 32;
    localparam int NOW_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_TICK     = 2'd2
    } t_op;

    // command that the front hands to the back through the queue
    typedef struct packed {
        t_op              op;
        logic [OBJ_W-1:0] obj;
        logic             kind;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_INSERT,
        BK_FIRE
    } t_back_state;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_DROP,
        CH_INSERT,
        CH_POP
    } t_chain_op;

endpackage

`default_nettype wire

FILE: sv/satq_if.sv
// valid/ready channel interfaces for command items and fired alarms
`timescale 1ns / 1ps
`default_nettype none

interface satq_in_if;
    import satq_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [OBJ_W-1:0]   object_index;
    logic               alarm_kind;
    logic [DELAY_W-1:0] delay_ticks;
    logic [NOW_W-1:0]   now_ticks;

    modport source (
        output valid, op, object_index, alarm_kind, delay_ticks, now_ticks,
        input  ready
    );
    modport sink (
        input  valid, op, object_index, alarm_kind, delay_ticks, now_ticks,
        output ready
    );
endinterface

interface satq_out_if;
    import satq_pkg::*;

    logic             valid;
    logic             ready;
    logic [OBJ_W-1:0] fired_object;
    logic             fired_kind;
    logic             last_fired;

    modport source (
        output valid, fired_object, fired_kind, last_fired,
        input  ready
    );
    modport sink (
        input  valid, fired_object, fired_kind, last_fired,
        output ready
    );
endinterface

`default_nettype wire

FILE: sv/satq_front.sv
// front end: accepts items, filters bad handles, computes saturated trigger times
`timescale 1ns / 1ps
`default_nettype none

module satq_front #(
    parameter int OWNER_COUNT     = 8,
    parameter int KINDS_PER_OWNER = 2,
    parameter int TIME_BITS       = 32
) (
    satq_in_if.sink                 i_item,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output satq_pkg::t_cmd_ctl      o_push_ctl,
    output logic [TIME_BITS-1:0]    o_push_time
);
    import satq_pkg::*;

    localparam int SUM_W = (TIME_BITS > 33) ? TIME_BITS : 33;
    localparam logic [SUM_W-1:0] TMAX = SUM_W'({TIME_BITS{1'b1}});

    logic [SUM_W-1:0] now_x;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] trig;
    logic             handle_ok;
    t_op              op;

    assign i_item.ready = !i_q_full;

    assign op        = t_op'(i_item.op);
    assign now_x     = SUM_W'(i_item.now_ticks) & TMAX;
    assign sum       = now_x + SUM_W'(i_item.delay_ticks);
    assign trig      = (sum > TMAX) ? TMAX : sum;
    assign handle_ok = (32'(i_item.object_index) < OWNER_COUNT) &&
                       (32'(i_item.alarm_kind) < KINDS_PER_OWNER);

    always_comb begin
        o_push          = 1'b0;
        o_push_ctl.op   = op;
        o_push_ctl.obj  = i_item.object_index;
        o_push_ctl.kind = i_item.alarm_kind;
        o_push_time     = trig[TIME_BITS-1:0];
        unique case (op) inside
            OP_REGISTER, OP_CANCEL: begin
                o_push = i_item.valid && handle_ok;
            end
            OP_TICK: begin
                o_push      = i_item.valid;
                o_push_time = now_x[TIME_BITS-1:0];
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/satq_fifo.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module satq_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_pop_data,
    output logic                   o_empty
);
    localparam int DEPTH = 2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full     = (r_count == 2'(DEPTH));
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/satq_back.sv
// back end: sorted alarm chain, command sequencer and fired-alarm output register
`timescale 1ns / 1ps
`default_nettype none

module satq_back #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_empty,
    input  wire satq_pkg::t_cmd_ctl   i_hd_ctl,
    input  wire logic [TIME_BITS-1:0] i_hd_time,
    output logic                      o_q_pop,
    satq_out_if.source                o_fired
);
    import satq_pkg::*;

    localparam logic [SLOTS-1:0] ONES = {SLOTS{1'b1}};

    t_back_state          r_state;
    t_back_state          n_state;
    t_chain_op            chain_op;

    logic [TIME_BITS-1:0] r_time [SLOTS];
    logic [OBJ_W-1:0]     r_obj  [SLOTS];
    logic [SLOTS-1:0]     r_kind;
    logic [SLOTS-1:0]     r_valid;
    logic [TIME_BITS-1:0] n_time [SLOTS];
    logic [OBJ_W-1:0]     n_obj  [SLOTS];
    logic [SLOTS-1:0]     n_kind;
    logic [SLOTS-1:0]     n_valid;

    logic [SLOTS-1:0]     match;
    logic [SLOTS-1:0]     cmp;
    logic [SLOTS-1:0]     shl;
    logic [SLOTS:0]       cmp_lo;
    logic [SLOTS:0]       cmp_hi;

    logic                 r_out_valid;
    logic [OBJ_W-1:0]     r_out_obj;
    logic                 r_out_kind;
    logic                 r_out_last;
    logic                 out_free;
    logic                 load_out;

    assign out_free = !r_out_valid || o_fired.ready;

    assign o_fired.valid        = r_out_valid;
    assign o_fired.fired_object = r_out_obj;
    assign o_fired.fired_kind   = r_out_kind;
    assign o_fired.last_fired   = r_out_last;

    // per-cell handle match and time compare against the queue head
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_valid[i] && (r_obj[i] == i_hd_ctl.obj) &&
                       (r_kind[i] == i_hd_ctl.kind);
            cmp[i]   = r_valid[i] && (r_time[i] <= i_hd_time);
            shl[i]   = |(match & (ONES >> (SLOTS - 1 - i)));
        end
    end

    assign cmp_lo = {cmp, 1'b1};
    assign cmp_hi = {1'b0, cmp};

    always_comb begin
        n_state  = r_state;
        chain_op = CH_HOLD;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_hd_ctl.op)
                        OP_REGISTER: begin
                            chain_op = CH_DROP;
                            n_state  = BK_INSERT;
                        end
                        OP_CANCEL: begin
                            chain_op = CH_DROP;
                            o_q_pop  = 1'b1;
                        end
                        OP_TICK: begin
                            n_state = BK_FIRE;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_INSERT: begin
                chain_op = CH_INSERT;
                o_q_pop  = 1'b1;
                n_state  = BK_IDLE;
            end
            BK_FIRE: begin
                if (cmp[0]) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        chain_op = CH_POP;
                        if (!cmp_hi[1]) begin
                            o_q_pop = 1'b1;
                            n_state = BK_IDLE;
                        end
                    end
                end else begin
                    o_q_pop = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // next contents of every chain cell
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_time[i]  = r_time[i];
            n_obj[i]   = r_obj[i];
            n_kind[i]  = r_kind[i];
            n_valid[i] = r_valid[i];
            case (chain_op) inside
                CH_DROP, CH_POP: begin
                    if (chain_op == CH_POP || shl[i]) begin
                        if (i < SLOTS - 1) begin
                            n_time[i]  = r_time[i+1];
                            n_obj[i]   = r_obj[i+1];
                            n_kind[i]  = r_kind[i+1];
                            n_valid[i] = r_valid[i+1];
                        end else begin
                            n_valid[i] = 1'b0;
                        end
                    end
                end
                CH_INSERT: begin
                    // full chain drops the new alarm
                    if (!r_valid[SLOTS-1] && !cmp[i]) begin
                        if (cmp_lo[i]) begin
                            n_time[i]  = i_hd_time;
                            n_obj[i]   = i_hd_ctl.obj;
                            n_kind[i]  = i_hd_ctl.kind;
                            n_valid[i] = 1'b1;
                        end else if (i > 0) begin
                            n_time[i]  = r_time[i-1];
                            n_obj[i]   = r_obj[i-1];
                            n_kind[i]  = r_kind[i-1];
                            n_valid[i] = r_valid[i-1];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_fired.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_obj  <= n_obj;
        r_kind <= n_kind;
        if (load_out) begin
            r_out_obj  <= r_obj[0];
            r_out_kind <= r_kind[0];
            r_out_last <= !cmp_hi[1];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sorted_alarm_timer_queue_core.sv
// top level of the sorted alarm timer queue
// an item enters the command queue at its accepting edge; for a tick the back moves from
// idle to fire state, which loads each due alarm into the output register when free;
// the front takes one item a cycle while the queue has room; register first drops, then
// inserts, cancel only drops; drop and insert are separate chain shifts
// synchronous active-low reset empties the chain and queue at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module sorted_alarm_timer_queue_core #(
    parameter int OWNER_COUNT     = 8,
    parameter int KINDS_PER_OWNER = 2,
    parameter int TIME_BITS       = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    satq_in_if.sink    i_item,
    satq_out_if.source o_fired
);
    import satq_pkg::*;

    // one chain cell per possible handle
    localparam int SLOTS  = OWNER_COUNT * KINDS_PER_OWNER;
    localparam int CTL_W  = $bits(t_cmd_ctl);
    localparam int DATA_W = CTL_W + TIME_BITS;

    // front to queue
    logic                 push;
    t_cmd_ctl             push_ctl;
    logic [TIME_BITS-1:0] push_time;
    logic                 q_full;

    // queue to back
    logic                 q_pop;
    logic                 q_empty;
    logic [DATA_W-1:0]    q_data;
    t_cmd_ctl             hd_ctl;
    logic [TIME_BITS-1:0] hd_time;

    // head of queue: control in the upper bits, time or trigger below
    assign hd_ctl  = t_cmd_ctl'(q_data[DATA_W-1:TIME_BITS]);
    assign hd_time = q_data[TIME_BITS-1:0];

    // front: handle filter and saturating add of now plus delay
    satq_front #(
        .OWNER_COUNT     (OWNER_COUNT),
        .KINDS_PER_OWNER (KINDS_PER_OWNER),
        .TIME_BITS       (TIME_BITS)
    ) u_front (
        .i_item      (i_item),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_ctl  (push_ctl),
        .o_push_time (push_time)
    );

    // short command queue lets the front keep taking items while the back works
    satq_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_ctl, push_time}),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_data),
        .o_empty     (q_empty)
    );

    // back: sorted chain, drop / insert / pop sequencer, output register
    satq_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_hd_ctl  (hd_ctl),
        .i_hd_time (hd_time),
        .o_q_pop   (q_pop),
        .o_fired   (o_fired)
    );

endmodule

`default_nettype wire

FILE: sv/satq_checker.sv
// port-level checks on the fired-alarm channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module satq_checker #(
    parameter int OWNER_COUNT     = 8,
    parameter int KINDS_PER_OWNER = 2
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_fired_object,
    input wire logic       i_fired_kind,
    input wire logic       i_last_fired
);

    // nothing fires right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("fired alarm shown right after reset");

    // a fired handle is always one that can be registered
    a_handle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_fired_object) < OWNER_COUNT) &&
                        (32'(i_fired_kind) < KINDS_PER_OWNER))
        else $error("fired alarm with out-of-range handle");

    // a stalled result stays up
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("fired alarm dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_fired_object) && $stable(i_fired_kind) && $stable(i_last_fired))
        else $error("fired alarm changed while stalled");

endmodule

bind sorted_alarm_timer_queue_core satq_checker #(
    .OWNER_COUNT     (OWNER_COUNT),
    .KINDS_PER_OWNER (KINDS_PER_OWNER)
) u_satq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_fired.valid),
    .i_out_ready    (o_fired.ready),
    .i_fired_object (o_fired.fired_object),
    .i_fired_kind   (o_fired.fired_kind),
    .i_last_fired   (o_fired.last_fired)
);

`default_nettype wire

FILE: test/tb_sorted_alarm_timer_queue_core.sv
// self-checking testbench for the sorted alarm timer queue core
`timescale 1ns / 1ps

module tb_sorted_alarm_timer_queue_core;
    import satq_pkg::*;

    localparam int SLOT_COUNT = 16;                 // owners times kinds
    localparam int HANDLE_W = 4;
    localparam int RANDOM_ITEMS = 120;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;  // op code the block must ignore
    localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

    // one alarm expected on the fired channel
    typedef struct packed {
        logic [OBJ_W-1:0] obj;
        logic             kind;
        logic             last;
    } fired_alarm_t;

    // mirror of the sorted chain plus the list of alarms still owed by the block
    class alarm_scoreboard;
        logic [NOW_W-1:0]    chain_time [SLOT_COUNT];
        logic [HANDLE_W-1:0] chain_handle [SLOT_COUNT];
        int                  chain_len;
        fired_alarm_t        due_alarms [$];
        int                  mismatches;

        function new();
            chain_len = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return due_alarms.size();
        endfunction

        function void drop_handle(logic [HANDLE_W-1:0] h);
            int pos;
            pos = -1;
            for (int i = 0; i < chain_len; i++)
                if (pos < 0 && chain_handle[i] == h) pos = i;
            if (pos >= 0) begin
                for (int i = pos; i + 1 < chain_len; i++) begin
                    chain_time[i] = chain_time[i + 1];
                    chain_handle[i] = chain_handle[i + 1];
                end
                chain_len--;
            end
        endfunction

        // new entry goes behind every entry with an equal or earlier time
        function void insert_alarm(logic [HANDLE_W-1:0] h, logic [NOW_W-1:0] t);
            int pos;
            pos = 0;
            if (chain_len >= SLOT_COUNT) return;
            while (pos < chain_len && chain_time[pos] <= t) pos++;
            for (int i = chain_len; i > pos; i--) begin
                chain_time[i] = chain_time[i - 1];
                chain_handle[i] = chain_handle[i - 1];
            end
            chain_time[pos] = t;
            chain_handle[pos] = h;
            chain_len++;
        endfunction

        function void note_command(logic [OP_W-1:0] op, logic [OBJ_W-1:0] obj, logic kind,
                                   logic [DELAY_W-1:0] delay, logic [NOW_W-1:0] now);
            logic [HANDLE_W-1:0] h;
            logic [NOW_W:0]      sum;
            int                  expired;
            h = {obj, kind};
            case (op)
                OP_REGISTER: begin
                    drop_handle(h);
                    sum = {1'b0, now} + {1'b0, delay};
                    insert_alarm(h, sum[NOW_W] ? TIME_MAX : sum[NOW_W-1:0]);
                end
                OP_CANCEL: drop_handle(h);
                OP_TICK: begin
                    expired = 0;
                    while (expired < chain_len && chain_time[expired] <= now) expired++;
                    for (int i = 0; i < expired; i++)
                        due_alarms.push_back({chain_handle[i][HANDLE_W-1:1],
                                              chain_handle[i][0], i == expired - 1});
                    for (int i = 0; i + expired < chain_len; i++) begin
                        chain_time[i] = chain_time[i + expired];
                        chain_handle[i] = chain_handle[i + expired];
                    end
                    chain_len -= expired;
                end
                default: ;
            endcase
        endfunction

        function void check_fired(logic [OBJ_W-1:0] obj, logic kind, logic last);
            fired_alarm_t want;
            if (due_alarms.size() == 0) begin
                $display("%0t: unexpected alarm obj %0d kind %0d last %0d",
                         $time, obj, kind, last);
                mismatches++;
                return;
            end
            want = due_alarms.pop_front();
            if (want.obj != obj || want.kind != kind || want.last != last) begin
                $display("%0t: expected obj %0d kind %0d last %0d, got obj %0d kind %0d last %0d",
                         $time, want.obj, want.kind, want.last, obj, kind, last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    satq_in_if  in_if ();
    satq_out_if out_if ();

    sorted_alarm_timer_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_if),
        .o_fired (out_if)
    );

    always #5 i_clk = ~i_clk;

    alarm_scoreboard sb;
    bit tx_idle = 1'b1;        // sender inserts random gaps
    bit rx_idle = 1'b1;        // receiver inserts random stalls
    int rx_hold_cycles = 0;    // request for one long receiver stall
    int live_items = 0;        // accepted items with a defined op
    int cycle_count = 0;

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one command item, optionally after a random gap, and wait for the handshake
    task automatic send_item(input logic [OP_W-1:0] op, input logic [OBJ_W-1:0] obj,
                             input logic kind, input logic [DELAY_W-1:0] delay,
                             input logic [NOW_W-1:0] now);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.object_index <= obj;
        in_if.alarm_kind   <= kind;
        in_if.delay_ticks  <= delay;
        in_if.now_ticks    <= now;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_command(op, obj, kind, delay, now);
        if (op != OP_RESERVED) live_items++;
    endtask

    // sender goes quiet until every owed alarm has come out
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // fired alarm sink: random stalls, plus one long hold when asked
    initial begin : fired_sink
        int stall;
        int hold;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                out_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                stall = rx_idle ? $urandom_range(0, 6) : 0;
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            // leave the wait early if a long hold is requested
            while (!out_if.valid && rx_hold_cycles == 0) @(posedge i_clk);
            if (out_if.valid)
                sb.check_fired(out_if.fired_object, out_if.fired_kind, out_if.last_fired);
        end
    end

    initial begin : stimulus
        logic [NOW_W-1:0]   wall_clock;
        logic [DELAY_W-1:0] delay;
        int                 stop_at;
        int                 n_reg;

        sb = new();
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_TICK;
        in_if.object_index <= '0;
        in_if.alarm_kind   <= 1'b0;
        in_if.delay_ticks  <= '0;
        in_if.now_ticks    <= '0;
        out_if.ready       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero delay fires on a tick at the same time
        send_item(OP_REGISTER, 3'd0, 1'b0, 32'd0, 32'd0);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'd0);
        // nothing pending, nothing fires
        send_item(OP_TICK, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'd5);
        // equal trigger times keep registration order
        send_item(OP_REGISTER, 3'd7, 1'b1, 32'd10, 32'd100);
        send_item(OP_REGISTER, 3'd3, 1'b0, 32'd10, 32'd100);
        send_item(OP_REGISTER, 3'd5, 1'b0, 32'd10, 32'd100);
        // re-register moves a pending alarm instead of duplicating it
        send_item(OP_REGISTER, 3'd7, 1'b1, 32'd5, 32'd100);
        send_item(OP_REGISTER, 3'd5, 1'b0, 32'd40, 32'd100);
        // cancel of a handle with nothing pending
        send_item(OP_CANCEL, 3'd5, 1'b1, 32'd0, 32'd100);
        // undefined op code leaves everything alone
        send_item(OP_RESERVED, 3'd2, 1'b1, 32'd0, 32'd100);
        send_item(OP_RESERVED, 3'd7, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // trigger saturates at the largest time, and hits it exactly
        send_item(OP_REGISTER, 3'd2, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_item(OP_REGISTER, 3'd4, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_REGISTER, 3'd6, 1'b1, 32'd20, 32'd100);
        send_item(OP_CANCEL, 3'd6, 1'b1, 32'd0, 32'd100);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'd109);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'd110);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'hFFFF_FFFE);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, TIME_MAX);

        // backpressure: sink holds off while the sender keeps pushing a full chain
        wait_drained();
        tx_idle = 1'b0;
        rx_hold_cycles = 300;
        for (int h = 0; h < SLOT_COUNT; h++)
            send_item(OP_REGISTER, h[HANDLE_W-1:1], h[0], 32'd0, 32'd1000);
        send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'd1000);
        for (int h = 0; h < 12; h++) begin
            send_item(OP_REGISTER, h[HANDLE_W-1:1], h[0], 32'd0, 32'd1001);
            if (h % 3 == 2) send_item(OP_TICK, 3'd0, 1'b0, 32'd0, 32'd1001);
        end
        wait_drained();

        // random bursts: a few registers with a cancel now and then, followed by a tick
        wall_clock = 32'd5000;
        stop_at = live_items + RANDOM_ITEMS;
        while (live_items < stop_at) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0: wall_clock = $urandom;                            // jump, maybe backward
                1: wall_clock = TIME_MAX - $urandom_range(0, 64);    // near the end of time
                2: wait_drained();
                3: send_item(OP_W'($urandom_range(0, 3)), OBJ_W'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), $urandom, $urandom);
                default: ;
            endcase
            n_reg = $urandom_range(1, 6);
            for (int i = 0; i < n_reg; i++) begin
                case ($urandom_range(0, 9))
                    0: delay = $urandom;
                    1: delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: delay = $urandom_range(0, 40);
                endcase
                send_item(OP_REGISTER, OBJ_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          delay, wall_clock);
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_CANCEL, OBJ_W'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), $urandom, wall_clock);
            end
            wall_clock = wall_clock + $urandom_range(0, 30);
            send_item(OP_TICK, OBJ_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      $urandom, wall_clock);
            // occasional flush so saturated alarms do not clog the chain
            if ($urandom_range(0, 7) == 0)
                send_item(OP_TICK, OBJ_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                          $urandom, TIME_MAX);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
